// ===== src/tem_pkg.sv =====
`default_nettype none

package tem_pkg;

	// scratch memory map: edge-matrix rows, edge vectors, cofactor vectors
	localparam int SCR_DEPTH = 39;
	localparam int SCR_AW = 6;
	localparam logic [SCR_AW-1:0] ADDR_B = 6'd0;
	localparam logic [SCR_AW-1:0] ADDR_E = 6'd9;
	localparam logic [SCR_AW-1:0] ADDR_C = 6'd27;

	localparam int KSHIFT = 49;
	localparam int MSHIFT = 16;

	localparam int PRE_LEN = 84;
	localparam logic [2:0] LAST_EDGE = 3'd5;
	localparam logic [2:0] LAST_GRP = 3'd4;
	localparam logic [1:0] LAST_DIM = 2'd2;

	typedef enum logic [1:0] {
		DST_RAM  = 2'd0,
		DST_DET  = 2'd1,
		DST_KNUM = 2'd2,
		DST_MNUM = 2'd3
	} dest_t;

	// one multiply-accumulate term
	typedef struct packed {
		logic              a_vert;
		logic [SCR_AW-1:0] a_addr;
		logic              b_one;
		logic [SCR_AW-1:0] b_addr;
		logic              neg;
		logic              dbl;
		logic              last;
		dest_t             dest;
		logic [SCR_AW-1:0] w_addr;
	} uop_t;

	typedef uop_t [PRE_LEN-1:0] pre_prog_t;

	typedef struct packed {
		uop_t       uop;
		logic       vert_we;
		logic [1:0] vert_idx;
		logic       load;
		logic       step;
		logic       msb;
		logic       wb;
		logic       div_start;
		logic       out_load;
		logic [2:0] row;
		logic [2:0] col;
		logic       last;
	} cmd_t;

	typedef struct packed {
		logic degen;
		logic div_done;
	} sts_t;

	function automatic logic [1:0] pair_lo(input logic [2:0] e);
		logic [1:0] r;
		case (e)
			3'd0, 3'd1, 3'd2: r = 2'd0;
			3'd3, 3'd4:       r = 2'd1;
			default:          r = 2'd2;
		endcase
		return r;
	endfunction

	function automatic logic [1:0] pair_hi(input logic [2:0] e);
		logic [1:0] r;
		case (e)
			3'd0:       r = 2'd1;
			3'd1, 3'd3: r = 2'd2;
			default:    r = 2'd3;
		endcase
		return r;
	endfunction

	// edge vector of edge k is vertex evec_p(k) minus vertex evec_q(k)
	function automatic int evec_p(input int k);
		int r;
		case (k)
			0:       r = 2;
			1:       r = 3;
			2:       r = 1;
			3:       r = 0;
			4:       r = 2;
			default: r = 0;
		endcase
		return r;
	endfunction

	function automatic int evec_q(input int k);
		int r;
		case (k)
			0:       r = 3;
			1:       r = 1;
			2:       r = 2;
			3:       r = 3;
			4:       r = 0;
			default: r = 1;
		endcase
		return r;
	endfunction

	function automatic uop_t mk_uop(input logic av, input int aa, input logic bo, input int ba,
			input logic ng, input logic lst, input dest_t ds, input int wa);
		uop_t u;
		u.a_vert = av;
		u.a_addr = SCR_AW'(aa);
		u.b_one = bo;
		u.b_addr = SCR_AW'(ba);
		u.neg = ng;
		u.dbl = 1'b0;
		u.last = lst;
		u.dest = ds;
		u.w_addr = SCR_AW'(wa);
		return u;
	endfunction

	function automatic pre_prog_t pre_program();
		pre_prog_t p;
		int n;
		int i;
		int d;
		int k;
		int u;
		int v;
		int ps;
		int ss;
		n = 0;
		for (i = 0; i < 3; i++) begin
			for (d = 0; d < 3; d++) begin
				p[n] = mk_uop(1'b1, i*3 + d, 1'b1, 0, 1'b0, 1'b0, DST_RAM, 0);
				n++;
				p[n] = mk_uop(1'b1, 9 + d, 1'b1, 0, 1'b1, 1'b1, DST_RAM, int'(ADDR_B) + i*3 + d);
				n++;
			end
		end
		for (k = 0; k < 6; k++) begin
			for (d = 0; d < 3; d++) begin
				p[n] = mk_uop(1'b1, evec_p(k)*3 + d, 1'b1, 0, 1'b0, 1'b0, DST_RAM, 0);
				n++;
				p[n] = mk_uop(1'b1, evec_q(k)*3 + d, 1'b1, 0, 1'b1, 1'b1, DST_RAM,
					int'(ADDR_E) + k*3 + d);
				n++;
			end
		end
		for (k = 0; k < 3; k++) begin
			for (d = 0; d < 3; d++) begin
				u = (k + 1) % 3;
				v = (k + 2) % 3;
				ps = (d + 1) % 3;
				ss = (d + 2) % 3;
				p[n] = mk_uop(1'b0, int'(ADDR_B) + u*3 + ps, 1'b0, int'(ADDR_B) + v*3 + ss,
					1'b0, 1'b0, DST_RAM, 0);
				n++;
				p[n] = mk_uop(1'b0, int'(ADDR_B) + u*3 + ss, 1'b0, int'(ADDR_B) + v*3 + ps,
					1'b1, 1'b1, DST_RAM, int'(ADDR_C) + k*3 + d);
				n++;
			end
		end
		for (d = 0; d < 3; d++) begin
			for (k = 0; k < 3; k++) begin
				p[n] = mk_uop(1'b0, int'(ADDR_C) + k*3 + d, 1'b1, 0, 1'b1, k == 2, DST_RAM,
					int'(ADDR_C) + 9 + d);
				n++;
			end
		end
		for (d = 0; d < 3; d++) begin
			p[n] = mk_uop(1'b0, int'(ADDR_B) + d, 1'b0, int'(ADDR_C) + d, 1'b0, d == 2,
				DST_DET, 0);
			n++;
		end
		return p;
	endfunction

	localparam pre_prog_t PRE_PROG = pre_program();

	// terms of one matrix entry: group 0 is the curl-curl dot, 1..4 the mass terms
	function automatic uop_t ent_uop(input logic [2:0] row, input logic [2:0] col,
			input logic [2:0] grp, input logic [1:0] dd);
		uop_t u;
		logic [1:0] ea;
		logic [1:0] eb;
		logic [1:0] ec;
		logic [1:0] ed;
		logic [1:0] x;
		logic [1:0] y;
		logic [1:0] pv;
		logic [1:0] qv;
		logic ng;
		ea = pair_lo(row);
		eb = pair_hi(row);
		ec = pair_lo(col);
		ed = pair_hi(col);
		x = ea;
		y = ec;
		pv = eb;
		qv = ed;
		ng = 1'b0;
		u = '0;
		if (grp == 3'd0) begin
			u.a_addr = ADDR_E + SCR_AW'(row) * SCR_AW'(3) + SCR_AW'(dd);
			u.b_addr = ADDR_E + SCR_AW'(col) * SCR_AW'(3) + SCR_AW'(dd);
			u.last = (dd == LAST_DIM);
			u.dest = DST_KNUM;
		end else begin
			case (grp)
				3'd1: begin
					x = ea; y = ec; pv = eb; qv = ed; ng = 1'b0;
				end
				3'd2: begin
					x = ea; y = ed; pv = eb; qv = ec; ng = 1'b1;
				end
				3'd3: begin
					x = eb; y = ec; pv = ea; qv = ed; ng = 1'b1;
				end
				default: begin
					x = eb; y = ed; pv = ea; qv = ec; ng = 1'b0;
				end
			endcase
			u.a_addr = ADDR_C + SCR_AW'(pv) * SCR_AW'(3) + SCR_AW'(dd);
			u.b_addr = ADDR_C + SCR_AW'(qv) * SCR_AW'(3) + SCR_AW'(dd);
			u.neg = ng;
			u.dbl = (x == y);
			u.last = (grp == LAST_GRP) && (dd == LAST_DIM);
			u.dest = DST_MNUM;
		end
		return u;
	endfunction

endpackage

`default_nettype wire

// ===== src/tem_vertex_if.sv =====
`default_nettype none

interface tem_vertex_if #(
	parameter int COORD_WIDTH = 32
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] coord_x;
	logic signed [COORD_WIDTH-1:0] coord_y;
	logic signed [COORD_WIDTH-1:0] coord_z;

	modport source (output valid, coord_x, coord_y, coord_z, input ready);
	modport sink (input valid, coord_x, coord_y, coord_z, output ready);
endinterface

`default_nettype wire

// ===== src/tem_entry_if.sv =====
`default_nettype none

interface tem_entry_if #(
	parameter int RESULT_WIDTH = 64
);
	logic                           valid;
	logic                           ready;
	logic [2:0]                     row_edge;
	logic [2:0]                     col_edge;
	logic signed [RESULT_WIDTH-1:0] stiffness_entry;
	logic signed [RESULT_WIDTH-1:0] mass_entry;
	logic                           degenerate;
	logic                           last_entry;

	modport source (output valid, row_edge, col_edge, stiffness_entry, mass_entry,
		degenerate, last_entry, input ready);
	modport sink (input valid, row_edge, col_edge, stiffness_entry, mass_entry,
		degenerate, last_entry, output ready);
endinterface

`default_nettype wire

// ===== src/tet_edge_element_matrices.sv =====
`default_nettype none

// Whitney edge-element curl-curl and mass matrices of one tetrahedron. Send the four
// vertices as Q15.16 coordinates, one request each; after the fourth the block emits the
// 36 entries of both 6x6 matrices in row-major order (edges 01,02,03,12,13,23) as
// saturated Q31.32 values, and takes no vertex until the last entry has left. All the
// wide products run through one bit-serial multiply-accumulate unit, one multiplier bit
// per cycle: 84 terms set up the element and each entry adds 15 terms plus two parallel
// restoring divisions. A zero-determinant element flags every entry.
module tet_edge_element_matrices #(
	parameter int COORD_WIDTH = 32,
	parameter int RESULT_WIDTH = 64
) (
	input wire logic   clk,
	input wire logic   arst_n,
	tem_vertex_if.sink vertex,
	tem_entry_if.source entry
);
	localparam int ACC_W = 4*COORD_WIDTH + 24;
	localparam int OPW = 2*COORD_WIDTH + 2;

	tem_pkg::cmd_t cmd;
	tem_pkg::sts_t sts;

	tem_ctrl #(.OPW(OPW)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vertex.valid),
		.in_ready  (vertex.ready),
		.out_valid (entry.valid),
		.out_ready (entry.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	tem_datapath #(
		.CW    (COORD_WIDTH),
		.RW    (RESULT_WIDTH),
		.ACC_W (ACC_W),
		.OPW   (OPW)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.coord_x         (vertex.coord_x),
		.coord_y         (vertex.coord_y),
		.coord_z         (vertex.coord_z),
		.cmd             (cmd),
		.sts             (sts),
		.row_edge        (entry.row_edge),
		.col_edge        (entry.col_edge),
		.stiffness_entry (entry.stiffness_entry),
		.mass_entry      (entry.mass_entry),
		.degenerate      (entry.degenerate),
		.last_entry      (entry.last_entry)
	);
endmodule

`default_nettype wire

// ===== src/tem_ram.sv =====
`default_nettype none

module tem_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic      [WIDTH-1:0]         rdata_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_b
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_a_q;
	logic [WIDTH-1:0] rd_b_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rd_a_q <= mem_q[raddr_a];
		rd_b_q <= mem_q[raddr_b];
	end

	assign rdata_a = rd_a_q;
	assign rdata_b = rd_b_q;
endmodule

`default_nettype wire

// ===== src/tem_div.sv =====
`default_nettype none

module tem_div #(
	parameter int NW = 152,
	parameter int RW = 64
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] num,
	input  wire logic [NW-1:0] den,
	output logic               done,
	output logic [RW-1:0]      quo
);
	localparam int CNT_W = $clog2(RW);
	localparam logic [RW-1:0] MAX_V = {1'b0, {(RW-1){1'b1}}};
	localparam logic [RW-1:0] MIN_V = {1'b1, {(RW-1){1'b0}}};

	typedef enum logic [3:0] {
		D_IDLE = 4'b0001,
		D_PREP = 4'b0010,
		D_ITER = 4'b0100,
		D_FIN  = 4'b1000
	} phase_t;

	phase_t           phase_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic             neg_q;
	logic             ovf_q;
	logic [NW-1:0]    mag_q;
	logic [NW-1:0]    den_q;
	logic [NW-1:0]    rem_q;
	logic [RW-1:0]    lo_q;
	logic [RW-1:0]    qm_q;
	logic [RW-1:0]    res_q;

	logic [NW-1:0] high;
	logic [NW:0]   rem2;
	logic [NW:0]   diff;
	logic          ge;
	logic [RW-1:0] sat;

	assign high = mag_q >> RW;
	assign rem2 = {rem_q, lo_q[RW-1]};
	assign diff = rem2 - {1'b0, den_q};
	assign ge = rem2 >= {1'b0, den_q};

	always_comb begin
		if (!neg_q) begin
			sat = (ovf_q || qm_q[RW-1]) ? MAX_V : qm_q;
		end else begin
			sat = (ovf_q || qm_q > MIN_V) ? MIN_V : -qm_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= D_IDLE;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (phase_q)
				D_IDLE: begin
					if (start) begin
						phase_q <= D_PREP;
					end
				end
				D_PREP: begin
					cnt_q <= '0;
					phase_q <= D_ITER;
				end
				D_ITER: begin
					if (cnt_q == CNT_W'(RW - 1)) begin
						phase_q <= D_FIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				D_FIN: begin
					done_q <= 1'b1;
					phase_q <= D_IDLE;
				end
				default: phase_q <= D_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (phase_q)
			D_IDLE: begin
				if (start) begin
					neg_q <= num[NW-1];
					mag_q <= num[NW-1] ? -num : num;
					den_q <= den;
				end
			end
			D_PREP: begin
				// a quotient of RW bits or more saturates in any case
				ovf_q <= high >= den_q;
				rem_q <= high;
				lo_q <= mag_q[RW-1:0];
				qm_q <= '0;
			end
			D_ITER: begin
				rem_q <= ge ? diff[NW-1:0] : rem2[NW-1:0];
				lo_q <= {lo_q[RW-2:0], 1'b0};
				qm_q <= {qm_q[RW-2:0], ge};
			end
			D_FIN: begin
				res_q <= sat;
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign quo = res_q;
endmodule

`default_nettype wire

// ===== src/tem_datapath.sv =====
`default_nettype none

module tem_datapath #(
	parameter int CW = 32,
	parameter int RW = 64,
	parameter int ACC_W = 152,
	parameter int OPW = 66
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic signed [CW-1:0] coord_x,
	input  wire logic signed [CW-1:0] coord_y,
	input  wire logic signed [CW-1:0] coord_z,
	input  wire tem_pkg::cmd_t        cmd,
	output tem_pkg::sts_t             sts,
	output logic [2:0]                row_edge,
	output logic [2:0]                col_edge,
	output logic [RW-1:0]             stiffness_entry,
	output logic [RW-1:0]             mass_entry,
	output logic                      degenerate,
	output logic                      last_entry
);
	logic signed [CW-1:0]    vertex_q [12];
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] mcand_q;
	logic [OPW-1:0]          mplier_q;
	logic [ACC_W-1:0]        vol_q;
	logic                    degen_q;
	logic [ACC_W-1:0]        knum_q;
	logic [ACC_W-1:0]        mnum_q;

	logic [2:0]    row_q;
	logic [2:0]    col_q;
	logic [RW-1:0] stiff_q;
	logic [RW-1:0] mass_q;
	logic          degen_out_q;
	logic          last_q;

	logic [3:0]              vbase;
	logic [OPW-1:0]          rd_a;
	logic [OPW-1:0]          rd_b;
	logic signed [CW-1:0]    vtx_rd;
	logic signed [ACC_W-1:0] a_ext;
	logic signed [ACC_W-1:0] addend;
	logic                    sub;
	logic                    ram_we;
	logic [ACC_W-1:0]        dk;
	logic [ACC_W-1:0]        dm;
	logic                    k_done;
	logic                    m_done;
	logic [RW-1:0]           k_quo;
	logic [RW-1:0]           m_quo;

	assign vbase = ({2'b00, cmd.vert_idx} << 1) + {2'b00, cmd.vert_idx};
	assign vtx_rd = vertex_q[cmd.uop.a_addr[3:0]];
	assign a_ext = cmd.uop.a_vert ? ACC_W'(vtx_rd) : ACC_W'($signed(rd_a));
	assign addend = mplier_q[0] ? mcand_q : '0;
	// the top multiplier bit carries negative weight
	assign sub = cmd.uop.neg ^ cmd.msb;
	assign ram_we = cmd.wb && cmd.uop.last && (cmd.uop.dest == tem_pkg::DST_RAM);

	// divisors 3|D| and 120|D|
	assign dk = (vol_q << 1) + vol_q;
	assign dm = (vol_q << 7) - (vol_q << 3);

	tem_ram #(
		.WIDTH(OPW),
		.DEPTH(tem_pkg::SCR_DEPTH)
	) u_scratch (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (cmd.uop.w_addr),
		.wdata   (acc_q[OPW-1:0]),
		.raddr_a (cmd.uop.a_addr),
		.rdata_a (rd_a),
		.raddr_b (cmd.uop.b_addr),
		.rdata_b (rd_b)
	);

	tem_div #(.NW(ACC_W), .RW(RW)) u_kdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (knum_q),
		.den    (dk),
		.done   (k_done),
		.quo    (k_quo)
	);

	tem_div #(.NW(ACC_W), .RW(RW)) u_mdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (mnum_q),
		.den    (dm),
		.done   (m_done),
		.quo    (m_quo)
	);

	always_ff @(posedge clk) begin
		if (cmd.vert_we) begin
			vertex_q[vbase] <= coord_x;
			vertex_q[vbase + 4'd1] <= coord_y;
			vertex_q[vbase + 4'd2] <= coord_z;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (cmd.step) begin
			acc_q <= sub ? acc_q - addend : acc_q + addend;
		end else if (cmd.wb && cmd.uop.last) begin
			acc_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mcand_q <= cmd.uop.dbl ? (a_ext <<< 1) : a_ext;
			mplier_q <= cmd.uop.b_one ? OPW'(1) : rd_b;
		end else if (cmd.step) begin
			mcand_q <= mcand_q <<< 1;
			mplier_q <= mplier_q >> 1;
		end
		if (cmd.wb && cmd.uop.last) begin
			case (cmd.uop.dest)
				tem_pkg::DST_DET: begin
					vol_q <= acc_q[ACC_W-1] ? -acc_q : acc_q;
					degen_q <= acc_q == '0;
				end
				tem_pkg::DST_KNUM: knum_q <= acc_q <<< tem_pkg::KSHIFT;
				tem_pkg::DST_MNUM: mnum_q <= acc_q <<< tem_pkg::MSHIFT;
				default: ;
			endcase
		end
		if (cmd.out_load) begin
			row_q <= cmd.row;
			col_q <= cmd.col;
			last_q <= cmd.last;
			degen_out_q <= degen_q;
			stiff_q <= degen_q ? '0 : k_quo;
			mass_q <= degen_q ? '0 : m_quo;
		end
	end

	assign sts.degen = degen_q;
	assign sts.div_done = k_done && m_done;

	assign row_edge = row_q;
	assign col_edge = col_q;
	assign stiffness_entry = stiff_q;
	assign mass_entry = mass_q;
	assign degenerate = degen_out_q;
	assign last_entry = last_q;
endmodule

`default_nettype wire

// ===== src/tem_ctrl.sv =====
`default_nettype none

module tem_ctrl #(
	parameter int OPW = 66
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	input  wire tem_pkg::sts_t sts,
	output tem_pkg::cmd_t      cmd
);
	localparam int BIT_W = $clog2(OPW);
	localparam int PC_W = $clog2(tem_pkg::PRE_LEN);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b00000001,
		S_READ  = 8'b00000010,
		S_LOAD  = 8'b00000100,
		S_MUL   = 8'b00001000,
		S_WB    = 8'b00010000,
		S_DIV   = 8'b00100000,
		S_DWAIT = 8'b01000000,
		S_OUT   = 8'b10000000
	} state_t;

	state_t           state_q;
	logic [1:0]       vcnt_q;
	logic [PC_W-1:0]  pc_q;
	logic             ent_q;
	logic [2:0]       row_q;
	logic [2:0]       col_q;
	logic [2:0]       grp_q;
	logic [1:0]       dd_q;
	logic [BIT_W-1:0] bit_q;

	logic msb;
	logic skip;
	logic last_ent;

	assign msb = bit_q == BIT_W'(OPW - 1);
	// a flat element needs no arithmetic: emit zero entries straight away
	assign skip = ent_q && grp_q == 3'd0 && dd_q == 2'd0 && sts.degen;
	assign last_ent = row_q == tem_pkg::LAST_EDGE && col_q == tem_pkg::LAST_EDGE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			vcnt_q <= '0;
			pc_q <= '0;
			ent_q <= 1'b0;
			row_q <= '0;
			col_q <= '0;
			grp_q <= '0;
			dd_q <= '0;
			bit_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						vcnt_q <= vcnt_q + 2'd1;
						if (vcnt_q == 2'd3) begin
							pc_q <= '0;
							ent_q <= 1'b0;
							state_q <= S_READ;
						end
					end
				end
				S_READ: state_q <= skip ? S_OUT : S_LOAD;
				S_LOAD: begin
					bit_q <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					if (msb) begin
						state_q <= S_WB;
					end else begin
						bit_q <= bit_q + 1'b1;
					end
				end
				S_WB: begin
					if (!ent_q) begin
						if (pc_q == PC_W'(tem_pkg::PRE_LEN - 1)) begin
							ent_q <= 1'b1;
							row_q <= '0;
							col_q <= '0;
							grp_q <= '0;
							dd_q <= '0;
						end else begin
							pc_q <= pc_q + 1'b1;
						end
						state_q <= S_READ;
					end else if (grp_q == tem_pkg::LAST_GRP && dd_q == tem_pkg::LAST_DIM) begin
						state_q <= S_DIV;
					end else begin
						if (dd_q == tem_pkg::LAST_DIM) begin
							dd_q <= '0;
							grp_q <= grp_q + 3'd1;
						end else begin
							dd_q <= dd_q + 2'd1;
						end
						state_q <= S_READ;
					end
				end
				S_DIV: state_q <= S_DWAIT;
				S_DWAIT: begin
					if (sts.div_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_ready) begin
						grp_q <= '0;
						dd_q <= '0;
						if (col_q == tem_pkg::LAST_EDGE) begin
							col_q <= '0;
							if (row_q == tem_pkg::LAST_EDGE) begin
								row_q <= '0;
								ent_q <= 1'b0;
								state_q <= S_IDLE;
							end else begin
								row_q <= row_q + 3'd1;
								state_q <= S_READ;
							end
						end else begin
							col_q <= col_q + 3'd1;
							state_q <= S_READ;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd.uop = ent_q ? tem_pkg::ent_uop(row_q, col_q, grp_q, dd_q) : tem_pkg::PRE_PROG[pc_q];
		cmd.vert_we = (state_q == S_IDLE) && in_valid;
		cmd.vert_idx = vcnt_q;
		cmd.load = state_q == S_LOAD;
		cmd.step = state_q == S_MUL;
		cmd.msb = msb;
		cmd.wb = state_q == S_WB;
		cmd.div_start = state_q == S_DIV;
		cmd.out_load = ((state_q == S_READ) && skip) || ((state_q == S_DWAIT) && sts.div_done);
		cmd.row = row_q;
		cmd.col = col_q;
		cmd.last = last_ent;
	end

	assign in_ready = state_q == S_IDLE;
	assign out_valid = state_q == S_OUT;
endmodule

`default_nettype wire

// ===== src/tem_checker.sv =====
`default_nettype none

module tem_checker #(
	parameter int RESULT_WIDTH = 64
) (
	input wire logic                    clk,
	input wire logic                    arst_n,
	input wire logic                    in_ready,
	input wire logic                    out_valid,
	input wire logic                    out_ready,
	input wire logic [2:0]              row_edge,
	input wire logic [2:0]              col_edge,
	input wire logic [RESULT_WIDTH-1:0] stiffness_entry,
	input wire logic [RESULT_WIDTH-1:0] mass_entry,
	input wire logic                    degenerate,
	input wire logic                    last_entry
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(row_edge) && $stable(col_edge)
			&& $stable(stiffness_entry) && $stable(mass_entry) && $stable(last_entry))
		else $error("entry dropped or changed while stalled");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("vertex taken while entries pending");

	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_entry |-> row_edge == 3'd5 && col_edge == 3'd5)
		else $error("last entry flag off the final matrix position");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> stiffness_entry == '0 && mass_entry == '0)
		else $error("nonzero entry on a flat element");

	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last_entry |=> !out_valid && in_ready)
		else $error("no return to vertex input after the last entry");
endmodule

bind tet_edge_element_matrices tem_checker #(.RESULT_WIDTH(RESULT_WIDTH)) u_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_ready        (vertex.ready),
	.out_valid       (entry.valid),
	.out_ready       (entry.ready),
	.row_edge        (entry.row_edge),
	.col_edge        (entry.col_edge),
	.stiffness_entry (entry.stiffness_entry),
	.mass_entry      (entry.mass_entry),
	.degenerate      (entry.degenerate),
	.last_entry      (entry.last_entry)
);

`default_nettype wire
